>>> src/wstq_pkg.sv
// Package for the work-stealing task queues: parameter defaults, operation codes,
// result status codes. No dependencies.
package wstq_pkg;

  localparam int unsigned WorkersDef    = 4;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TaskBitsDef   = 16;

  // fixed field widths of the channels
  localparam int unsigned TaskIdW = 16;
  localparam int unsigned WorkerW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SrcW    = 2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

>>> src/wstq_if.sv
// Handshake channels of the task queues: request (push/pop) and response.
// Depends on wstq_pkg.
interface wstq_req_if
  import wstq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               func;
  logic [TaskIdW-1:0] task_id;
  logic [WorkerW-1:0] worker;

  modport source (output valid, func, task_id, worker, input ready);
  modport sink   (input valid, func, task_id, worker, output ready);
endinterface

interface wstq_rsp_if
  import wstq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [TaskIdW-1:0] popped_task;
  logic [SrcW-1:0]    source_queue;
  logic               stolen;

  modport source (output valid, status, popped_task, source_queue, stolen, input ready);
  modport sink   (input valid, status, popped_task, source_queue, stolen, output ready);
endinterface

>>> src/wstq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module wstq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/work_stealing_task_queues.sv
// Top level of the work-stealing task queues: queue bookkeeping, steal encoder, pipeline.
// Depends on wstq_pkg, wstq_if (wstq_req_if, wstq_rsp_if) and wstq_ram.
//
//   port    | dir | contents
//   --------+-----+---------------------------------------------------
//   req_i   | in  | func (push/pop), task_id (push), worker (pop)
//   rsp_o   | out | status, popped_task, source_queue, stolen
//
// - One item accepted per cycle while req_i.ready is high; each item gives one
//   result, registered first by the task store read, then by the output register.
// - Queue choice, full check and steal encoder run in the accept cycle from
//   the head/tail/count flops; the task store is a single RAM.
// - Reset empties all queues and points the next push at queue 0. The task
//   store is not cleared: a queue only reads entries it has written.
// - A stalled output holds its result; one more item is taken into the
//   RAM stage, after which req_i.ready drops until the output moves.
module work_stealing_task_queues
  import wstq_pkg::*;
#(
  parameter int unsigned WORKERS     = WorkersDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TASK_BITS   = TaskBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wstq_req_if.sink   req_i,
  wstq_rsp_if.source rsp_o
);

  localparam int unsigned QW       = $clog2(WORKERS);
  localparam int unsigned PW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RamDepth = WORKERS * (1 << PW);
  localparam int unsigned AW       = $clog2(RamDepth);

  // per-queue head, tail and fill count
  logic [PW-1:0] rd_ptr_q [WORKERS];
  logic [PW-1:0] wr_ptr_q [WORKERS];
  logic [CW-1:0] count_q  [WORKERS];
  logic [QW-1:0] push_q;   // round-robin push target

  // pipeline stage 1 (RAM read in flight) and stage 2 (output register)
  logic                s1_valid_q;
  logic [StatusW-1:0]  s1_status_q;
  logic [SrcW-1:0]     s1_src_q;
  logic                s1_stolen_q;
  logic                s1_take_q;
  logic                s2_valid_q;
  logic [StatusW-1:0]  s2_status_q;
  logic [TaskIdW-1:0]  s2_task_q;
  logic [SrcW-1:0]     s2_src_q;
  logic                s2_stolen_q;

  logic                s1_adv;
  logic                accept;
  logic                is_push;
  logic                push_full;
  logic                push_ok;
  logic                own_hit;
  logic                steal_hit;
  logic [QW-1:0]       own_q;
  logic [QW-1:0]       steal_q;
  logic [QW-1:0]       pop_q;
  logic                pop_ok;
  logic [TASK_BITS-1:0] rdata;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  // Handshake: stage 1 drains when the output register is free or taken.
  assign s1_adv      = !s2_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  // Push side: target is the round-robin pointer; full queues drop the task.
  assign is_push   = (req_i.func == FUNC_PUSH);
  assign push_full = (count_q[push_q] == CW'(QUEUE_DEPTH));
  assign push_ok   = is_push && !push_full;

  // Pop side: own queue first, else the lowest-numbered other non-empty queue.
  always_comb begin
    own_hit   = 1'b0;
    steal_hit = 1'b0;
    steal_q   = '0;
    for (int i = 0; i < WORKERS; i++) begin
      if (count_q[i] != '0) begin
        if (32'(req_i.worker) == i) begin
          own_hit = 1'b1;
        end else if (!steal_hit) begin
          steal_hit = 1'b1;
          steal_q   = QW'(i);
        end
      end
    end
  end

  assign own_q  = QW'(req_i.worker);
  assign pop_q  = own_hit ? own_q : steal_q;
  assign pop_ok = !is_push && (own_hit || steal_hit);

  wstq_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && push_ok),
    .waddr_i (AW'({push_q, wr_ptr_q[push_q]})),
    .wdata_i (TASK_BITS'(req_i.task_id)),
    .re_i    (accept && pop_ok),
    .raddr_i (AW'({pop_q, rd_ptr_q[pop_q]})),
    .rdata_o (rdata)
  );

  // Queue bookkeeping, updated in the accept cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORKERS; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        count_q[i]  <= '0;
      end
      push_q <= '0;
    end else if (accept) begin
      if (is_push) begin
        if (!push_full) begin
          wr_ptr_q[push_q] <= ptr_inc(wr_ptr_q[push_q]);
          count_q[push_q]  <= count_q[push_q] + CW'(1);
        end
        push_q <= (push_q == QW'(WORKERS - 1)) ? '0 : push_q + QW'(1);
      end else if (pop_ok) begin
        rd_ptr_q[pop_q] <= ptr_inc(rd_ptr_q[pop_q]);
        count_q[pop_q]  <= count_q[pop_q] - CW'(1);
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= accept;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_take_q <= pop_ok;
      if (is_push) begin
        s1_status_q <= push_full ? STATUS_FULL : STATUS_OK;
        s1_src_q    <= SrcW'(push_q);
        s1_stolen_q <= 1'b0;
      end else if (pop_ok) begin
        s1_status_q <= STATUS_OK;
        s1_src_q    <= SrcW'(pop_q);
        s1_stolen_q <= !own_hit;
      end else begin
        s1_status_q <= STATUS_EMPTY;
        s1_src_q    <= '0;
        s1_stolen_q <= 1'b0;
      end
    end
    if (s1_adv && s1_valid_q) begin
      s2_status_q <= s1_status_q;
      s2_task_q   <= s1_take_q ? TaskIdW'(rdata) : '0;
      s2_src_q    <= s1_src_q;
      s2_stolen_q <= s1_stolen_q;
    end
  end

  assign rsp_o.valid        = s2_valid_q;
  assign rsp_o.status       = s2_status_q;
  assign rsp_o.popped_task  = s2_task_q;
  assign rsp_o.source_queue = s2_src_q;
  assign rsp_o.stolen       = s2_stolen_q;

  // A queue never holds more than its depth.
  for (genvar g = 0; g < WORKERS; g++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[g] <= CW'(QUEUE_DEPTH))
      else $error("queue %0d fill count above depth", g);
  end

  // A stolen task is always a successful pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.stolen |-> rsp_o.status == STATUS_OK)
    else $error("stolen flag on a failed result");

  // An empty pop reports no task and queue zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STATUS_EMPTY
      |-> rsp_o.popped_task == '0 && rsp_o.source_queue == '0)
    else $error("empty pop carries a task");

  // An empty RAM stage always takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> req_i.ready)
    else $error("input stalled with empty pipeline");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the work-stealing task queues: push/pop items go in on
// req_i, each result on rsp_o is checked against an in-bench queue predictor.
// Depends on wstq_pkg, wstq_req_if, wstq_rsp_if and work_stealing_task_queues.
module tb_top;
  import wstq_pkg::*;

  localparam int NQ         = WorkersDef;
  localparam int DEPTH      = QueueDepthDef;
  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int TAIL_WAIT  = 8;      // extra wait after all results are back

  typedef struct packed {
    status_e            status;
    logic [TaskIdW-1:0] popped_task;
    logic [SrcW-1:0]    source_queue;
    logic               stolen;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  wstq_req_if req_if ();
  wstq_rsp_if rsp_if ();

  work_stealing_task_queues u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: one ring per worker plus the round-robin push pointer.
  // Only entries that were pushed are ever read back.
  // ---------------------------------------------------------------------------
  logic [TaskIdW-1:0] ring_mem [NQ][DEPTH];
  int                 head_ptr [NQ];
  int                 tail_ptr [NQ];
  int                 fill_lvl [NQ];
  int                 next_push_q;

  rsp_t        pending_rsp_q [$];
  rsp_t        want_rsp;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Works out the result of one item and advances the queue state.
  function automatic rsp_t queue_outcome(logic func, logic [TaskIdW-1:0] task_id,
                                         logic [WorkerW-1:0] worker);
    rsp_t r;
    int   q;
    bit   found;
    r.status       = STATUS_OK;
    r.popped_task  = '0;
    r.source_queue = '0;
    r.stolen       = 1'b0;
    found          = 1'b0;
    q              = 0;
    if (func == FUNC_PUSH) begin
      q = next_push_q;
      r.source_queue = SrcW'(q);
      if (fill_lvl[q] >= DEPTH) begin
        r.status = STATUS_FULL;   // dropped, pointer still moves on
      end else begin
        ring_mem[q][tail_ptr[q]] = task_id;
        tail_ptr[q] = (tail_ptr[q] + 1) % DEPTH;
        fill_lvl[q]++;
      end
      next_push_q = (q + 1) % NQ;
    end else begin
      if (fill_lvl[worker] != 0) begin
        q = worker;
        found = 1'b1;
      end else begin
        // own queue empty: lowest-numbered other non-empty queue wins
        for (int i = 0; i < NQ; i++) begin
          if (!found && i != int'(worker) && fill_lvl[i] != 0) begin
            q = i;
            found = 1'b1;
            r.stolen = 1'b1;
          end
        end
      end
      if (found) begin
        r.popped_task  = ring_mem[q][head_ptr[q]];
        r.source_queue = SrcW'(q);
        head_ptr[q] = (head_ptr[q] + 1) % DEPTH;
        fill_lvl[q]--;
      end else begin
        r.status = STATUS_EMPTY;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor at the falling edge: signals are stable there, so a handshake seen
  // now is the one taken at the next rising edge. Results are checked in order,
  // accepted requests are predicted, and the watchdog counts dead cycles.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("result with no pending item: status %0d task %0d",
                 rsp_if.status, rsp_if.popped_task);
          err_cnt++;
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          if (rsp_if.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, rsp_if.status);
            err_cnt++;
          end
          if (rsp_if.popped_task !== want_rsp.popped_task) begin
            $error("popped_task: expected %0d, got %0d",
                   want_rsp.popped_task, rsp_if.popped_task);
            err_cnt++;
          end
          if (rsp_if.source_queue !== want_rsp.source_queue) begin
            $error("source_queue: expected %0d, got %0d",
                   want_rsp.source_queue, rsp_if.source_queue);
            err_cnt++;
          end
          if (rsp_if.stolen !== want_rsp.stolen) begin
            $error("stolen: expected %0d, got %0d", want_rsp.stolen, rsp_if.stolen);
            err_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        pending_rsp_q.push_back(queue_outcome(req_if.func, req_if.task_id, req_if.worker));
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: ready drops at random with the current stall rate.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one item, after a random gap, and returns once it is taken.
  task automatic send_item(input logic func, input logic [TaskIdW-1:0] task_id,
                           input logic [WorkerW-1:0] worker);
    bit fired;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= func;
    req_if.task_id <= task_id;
    req_if.worker  <= worker;
    do begin
      @(negedge clk_i);
      fired = req_if.valid && req_if.ready;
      @(posedge clk_i);
    end while (!fired);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Pops on a cold block: every worker comes back empty-handed.
  task automatic test_pop_empty();
    for (int w = 0; w < NQ; w++) send_item(FUNC_POP, 16'hFFFF, WorkerW'(w));
  endtask

  // One task per queue via round robin, then each worker takes its own.
  task automatic test_own_queue();
    send_item(FUNC_PUSH, 16'h0000, 2'd3);
    send_item(FUNC_PUSH, 16'hFFFF, 2'd0);
    send_item(FUNC_PUSH, 16'hAAAA, 2'd1);
    send_item(FUNC_PUSH, 16'h5555, 2'd2);
    for (int w = 0; w < NQ; w++) send_item(FUNC_POP, 16'h0000, WorkerW'(w));
  endtask

  // Stealing: from the only loaded queue, then lowest-numbered first,
  // then pops that find nothing anywhere.
  task automatic test_steal_priority();
    send_item(FUNC_PUSH, 16'h1234, 2'd0);   // lands in queue 0
    send_item(FUNC_POP,  16'h0000, 2'd3);
    send_item(FUNC_PUSH, 16'h8001, 2'd0);   // queue 1
    send_item(FUNC_PUSH, 16'h7FFE, 2'd0);   // queue 2
    send_item(FUNC_POP,  16'h0000, 2'd3);   // steals from 1
    send_item(FUNC_POP,  16'h0000, 2'd1);   // 1 now empty, steals from 2
    send_item(FUNC_POP,  16'h0000, 2'd2);
    send_item(FUNC_POP,  16'h0000, 2'd0);
  endtask

  // Fill every queue past its depth so each one drops a push, then drain all
  // and a few more so empty pops follow.
  task automatic test_overflow();
    for (int k = 0; k < NQ * (DEPTH + 1); k++) begin
      send_item(FUNC_PUSH, TaskIdW'($urandom()), WorkerW'($urandom_range(3)));
    end
    for (int k = 0; k < NQ * (DEPTH + 1); k++) begin
      send_item(FUNC_POP, TaskIdW'($urandom()), WorkerW'($urandom_range(NQ - 1)));
    end
  endtask

  // Random mix in bursts whose push share swings between pop-heavy and
  // push-heavy, so the queues keep running dry and overflowing.
  task automatic test_random_mix(input int n_items);
    int push_pct;
    push_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      send_item(($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP,
                TaskIdW'($urandom()), WorkerW'($urandom_range(3)));
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_PUSH;
    req_if.task_id = '0;
    req_if.worker  = '0;
    err_cnt        = 0;
    idle_cycles    = 0;
    next_push_q    = 0;
    for (int q = 0; q < NQ; q++) begin
      head_ptr[q] = 0;
      tail_ptr[q] = 0;
      fill_lvl[q] = 0;
    end
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pop_empty();
    test_own_queue();
    test_steal_priority();
    wait_results_drained();   // sender holds off until every result is back

    set_idling(0, 65);
    test_overflow();
    wait_results_drained();

    set_idling(0, 0);
    test_random_mix(420);
    set_idling(65, 0);
    test_random_mix(420);
    wait_results_drained();
    set_idling(0, 65);
    test_random_mix(420);
    set_idling(28, 28);
    test_random_mix(420);

    wait_results_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
